// ===== rtl/row_projection_post_finder_assert.svh =====
// ----------------------------------------------------------------------------
// Row projection post finder assertion macros
// Shared concurrent assertion forms used by the post finder modules.
// ----------------------------------------------------------------------------
`ifndef ROW_PROJECTION_POST_FINDER_ASSERT_SVH
`define ROW_PROJECTION_POST_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPPF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("post finder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPPF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("post finder check failed");

`endif

// ===== rtl/rppf_pkg.sv =====
// ----------------------------------------------------------------------------
// Row projection post finder package
// Register indexes, reset values and queue sizing shared by the modules.
// ----------------------------------------------------------------------------
package rppf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MASK     = 2'd0,
    CFG_POST_THRESHOLD = 2'd1,
    CFG_LINE_COUNT     = 2'd2,
    CFG_LINE_LENGTH    = 2'd3
  } cfg_index_t;

  localparam logic [7:0] PIXEL_MASK_RST     = 8'h01;
  localparam logic [8:0] POST_THRESHOLD_RST = 9'd5;
  localparam logic [8:0] LINE_COUNT_RST     = 9'd256;
  localparam logic [8:0] LINE_LENGTH_RST    = 9'd256;

  localparam int QUEUE_DEPTH = 4;

  localparam int AREA_W = 17;
  localparam int SUM_OUT_W = 23;
  localparam int POS_OUT_W = 8;

endpackage

// ===== rtl/row_projection_post_finder.sv =====
// A result is registered in the back end once the record of the line that ends it has passed the line queue.
// Throughput is one pixel per cycle; the line queue decouples pixel intake
// from post merging, so a stalled result stalls input only once the queue fills.
// Reset is synchronous and active low: it restores the register defaults,
// empties the queue, closes any open post and returns the scan to line 0.
// ----------------------------------------------------------------------------
// Row projection post finder
// Segments a label image into posts by row projection and reports each post.
// ----------------------------------------------------------------------------
module row_projection_post_finder
  import rppf_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_post_valid,
  output logic [AREA_W-1:0]     out_area,
  output logic [SUM_OUT_W-1:0]  out_row_weighted_sum,
  output logic [SUM_OUT_W-1:0]  out_col_sum,
  output logic [POS_OUT_W-1:0]  out_first_line,
  output logic [POS_OUT_W-1:0]  out_last_line,
  output logic [POS_OUT_W-1:0]  out_min_col,
  output logic [POS_OUT_W-1:0]  out_max_col,
  output logic                  out_frame_last
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = $clog2(MAX_DIM * (MAX_DIM - 1) / 2 + 1);
  localparam int ROW_W = $clog2(MAX_DIM * (MAX_DIM - 1) + 1);
  localparam int REC_W = 1 + 3 * DIM_W + CNT_W + SUM_W + ROW_W;

  logic [7:0] pixel_mask_r;
  logic [8:0] post_threshold_r, line_count_r, line_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mask_r     <= PIXEL_MASK_RST;
      post_threshold_r <= POST_THRESHOLD_RST;
      line_count_r     <= LINE_COUNT_RST;
      line_length_r    <= LINE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_idx))
        CFG_PIXEL_MASK:     pixel_mask_r     <= cfg_wdata[7:0];
        CFG_POST_THRESHOLD: post_threshold_r <= cfg_wdata;
        CFG_LINE_COUNT:     line_count_r     <= cfg_wdata;
        CFG_LINE_LENGTH:    line_length_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  logic [REC_W-1:0] fq_data, qb_data;

  rppf_front #(
    .MAX_DIM (MAX_DIM),
    .REC_W   (REC_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_mask  (pixel_mask_r),
    .line_count  (line_count_r),
    .line_length (line_length_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel    (in_pixel),
    .rec_valid   (fq_valid),
    .rec_ready   (fq_ready),
    .rec_data    (fq_data)
  );

  rppf_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  rppf_back #(
    .MAX_DIM (MAX_DIM),
    .REC_W   (REC_W)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .post_threshold       (post_threshold_r),
    .rec_valid            (qb_valid),
    .rec_ready            (qb_ready),
    .rec_data             (qb_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_post_valid       (out_post_valid),
    .out_area             (out_area),
    .out_row_weighted_sum (out_row_weighted_sum),
    .out_col_sum          (out_col_sum),
    .out_first_line       (out_first_line),
    .out_last_line        (out_last_line),
    .out_min_col          (out_min_col),
    .out_max_col          (out_max_col),
    .out_frame_last       (out_frame_last)
  );

endmodule

// ===== rtl/rppf_front.sv =====
// ----------------------------------------------------------------------------
// Row projection post finder front end
// Classifies pixels, tracks the scan position and builds one line record
// per line, which it hands to the line queue at the end of the line.
// ----------------------------------------------------------------------------
module rppf_front
  import rppf_pkg::*;
#(
  parameter int MAX_DIM = 256,
  parameter int REC_W   = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       pixel_mask,
  input  logic [8:0]       line_count,
  input  logic [8:0]       line_length,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_pixel,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [REC_W-1:0] rec_data
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = $clog2(MAX_DIM * (MAX_DIM - 1) / 2 + 1);
  localparam int ROW_W = $clog2(MAX_DIM * (MAX_DIM - 1) + 1);

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [8:0] v);
    logic [CNT_W-1:0] r;
    if (v == 9'd0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  localparam logic [DIM_W-1:0] MIN_COL_RST = DIM_W'(clamp_dim(LINE_LENGTH_RST) - CNT_W'(1));

  logic [DIM_W-1:0] col_r, line_r, lmin_r, lmax_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] csum_r;
  logic [ROW_W-1:0] rsum_r;

  logic             hit, eol, eof, accept;
  logic [CNT_W-1:0] len_eff, lines_eff, col_ext, line_ext, cnt_upd;
  logic [DIM_W-1:0] min_upd, max_upd;
  logic [SUM_W-1:0] csum_upd;
  logic [ROW_W-1:0] rsum_upd;

  always_comb begin
    len_eff   = clamp_dim(line_length);
    lines_eff = clamp_dim(line_count);
    hit       = |(in_pixel & pixel_mask);
    col_ext   = CNT_W'(col_r) + CNT_W'(1);
    line_ext  = CNT_W'(line_r) + CNT_W'(1);
    eol       = col_ext >= len_eff;
    eof       = line_ext >= lines_eff;
    cnt_upd   = cnt_r + CNT_W'(hit);
    min_upd   = (hit && (col_r < lmin_r)) ? col_r : lmin_r;
    max_upd   = (hit && (col_r > lmax_r)) ? col_r : lmax_r;
    csum_upd  = csum_r + (hit ? SUM_W'(col_r) : '0);
    rsum_upd  = rsum_r + (hit ? ROW_W'(line_r) : '0);
  end

  assign in_ready  = !eol || rec_ready;
  assign accept    = in_valid && in_ready;
  assign rec_valid = accept && eol;
  assign rec_data  = {eof, line_r, cnt_upd, min_upd, max_upd, csum_upd, rsum_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      cnt_r  <= '0;
      lmin_r <= MIN_COL_RST;
      lmax_r <= '0;
      csum_r <= '0;
      rsum_r <= '0;
    end else if (accept) begin
      if (eol) begin
        col_r  <= '0;
        line_r <= eof ? '0 : DIM_W'(line_ext);
        cnt_r  <= '0;
        lmin_r <= DIM_W'(len_eff - CNT_W'(1));
        lmax_r <= '0;
        csum_r <= '0;
        rsum_r <= '0;
      end else begin
        col_r  <= DIM_W'(col_ext);
        cnt_r  <= cnt_upd;
        lmin_r <= min_upd;
        lmax_r <= max_upd;
        csum_r <= csum_upd;
        rsum_r <= rsum_upd;
      end
    end
  end

endmodule

// ===== rtl/rppf_queue.sv =====
// ----------------------------------------------------------------------------
// Row projection post finder line queue
// Small first-in first-out buffer of line records between front and back.
// ----------------------------------------------------------------------------
module rppf_queue
  import rppf_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/rppf_back.sv =====
// ----------------------------------------------------------------------------
// Row projection post finder back end
// Merges qualifying lines into posts and registers each finished result.
// ----------------------------------------------------------------------------
`include "row_projection_post_finder_assert.svh"

module rppf_back
  import rppf_pkg::*;
#(
  parameter int MAX_DIM = 256,
  parameter int REC_W   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [8:0]           post_threshold,
  input  logic                 rec_valid,
  output logic                 rec_ready,
  input  logic [REC_W-1:0]     rec_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_post_valid,
  output logic [AREA_W-1:0]    out_area,
  output logic [SUM_OUT_W-1:0] out_row_weighted_sum,
  output logic [SUM_OUT_W-1:0] out_col_sum,
  output logic [POS_OUT_W-1:0] out_first_line,
  output logic [POS_OUT_W-1:0] out_last_line,
  output logic [POS_OUT_W-1:0] out_min_col,
  output logic [POS_OUT_W-1:0] out_max_col,
  output logic                 out_frame_last
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = $clog2(MAX_DIM * (MAX_DIM - 1) / 2 + 1);
  localparam int ROW_W = $clog2(MAX_DIM * (MAX_DIM - 1) + 1);

  logic             rec_frame_end;
  logic [DIM_W-1:0] rec_line, rec_min, rec_max;
  logic [CNT_W-1:0] rec_cnt;
  logic [SUM_W-1:0] rec_csum;
  logic [ROW_W-1:0] rec_rsum;

  assign {rec_frame_end, rec_line, rec_cnt, rec_min, rec_max, rec_csum, rec_rsum} = rec_data;

  logic                 in_post_r, in_post_nxt;
  logic [AREA_W-1:0]    post_area_r, post_area_nxt;
  logic [SUM_OUT_W-1:0] post_row_sum_r, post_row_sum_nxt;
  logic [SUM_OUT_W-1:0] post_col_sum_r, post_col_sum_nxt;
  logic [DIM_W-1:0]     post_first_line_r, post_first_line_nxt;
  logic [DIM_W-1:0]     post_last_line_r, post_last_line_nxt;
  logic [DIM_W-1:0]     post_min_col_r, post_min_col_nxt;
  logic [DIM_W-1:0]     post_max_col_r, post_max_col_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_post_valid_r, out_frame_last_r;
  logic [AREA_W-1:0]    out_area_r;
  logic [SUM_OUT_W-1:0] out_row_sum_r, out_col_sum_r;
  logic [POS_OUT_W-1:0] out_first_line_r, out_last_line_r, out_min_col_r, out_max_col_r;

  logic pop, above, closed, emit, emit_post;

  assign rec_ready = !out_valid_r || out_ready;
  assign pop       = rec_valid && rec_ready;

  always_comb begin
    post_area_nxt       = post_area_r;
    post_row_sum_nxt    = post_row_sum_r;
    post_col_sum_nxt    = post_col_sum_r;
    post_first_line_nxt = post_first_line_r;
    post_last_line_nxt  = post_last_line_r;
    post_min_col_nxt    = post_min_col_r;
    post_max_col_nxt    = post_max_col_r;
    in_post_nxt         = in_post_r;
    above               = 32'(rec_cnt) > 32'(post_threshold);
    closed              = 1'b0;
    emit                = 1'b0;
    emit_post           = 1'b0;
    if (pop) begin
      if (above) begin
        if (!in_post_r) begin
          post_area_nxt       = AREA_W'(rec_cnt);
          post_row_sum_nxt    = SUM_OUT_W'(rec_rsum);
          post_col_sum_nxt    = SUM_OUT_W'(rec_csum);
          post_first_line_nxt = rec_line;
          post_min_col_nxt    = rec_min;
          post_max_col_nxt    = rec_max;
        end else begin
          post_area_nxt    = post_area_r + AREA_W'(rec_cnt);
          post_row_sum_nxt = post_row_sum_r + SUM_OUT_W'(rec_rsum);
          post_col_sum_nxt = post_col_sum_r + SUM_OUT_W'(rec_csum);
          if (rec_min < post_min_col_r) begin
            post_min_col_nxt = rec_min;
          end
          if (rec_max > post_max_col_r) begin
            post_max_col_nxt = rec_max;
          end
        end
        post_last_line_nxt = rec_line;
        in_post_nxt        = 1'b1;
      end else if (in_post_r) begin
        closed      = 1'b1;
        in_post_nxt = 1'b0;
      end
      if (rec_frame_end) begin
        in_post_nxt = 1'b0;
        emit        = 1'b1;
        emit_post   = closed || above;
      end else begin
        emit      = closed;
        emit_post = closed;
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_post_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_post_r   <= in_post_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    post_area_r       <= post_area_nxt;
    post_row_sum_r    <= post_row_sum_nxt;
    post_col_sum_r    <= post_col_sum_nxt;
    post_first_line_r <= post_first_line_nxt;
    post_last_line_r  <= post_last_line_nxt;
    post_min_col_r    <= post_min_col_nxt;
    post_max_col_r    <= post_max_col_nxt;
    if (emit) begin
      out_post_valid_r <= emit_post;
      out_frame_last_r <= rec_frame_end;
      out_area_r       <= emit_post ? post_area_nxt : '0;
      out_row_sum_r    <= emit_post ? post_row_sum_nxt : '0;
      out_col_sum_r    <= emit_post ? post_col_sum_nxt : '0;
      out_first_line_r <= emit_post ? POS_OUT_W'(post_first_line_nxt) : '0;
      out_last_line_r  <= emit_post ? POS_OUT_W'(post_last_line_nxt) : '0;
      out_min_col_r    <= emit_post ? POS_OUT_W'(post_min_col_nxt) : '0;
      out_max_col_r    <= emit_post ? POS_OUT_W'(post_max_col_nxt) : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_post_valid       = out_post_valid_r;
  assign out_area             = out_area_r;
  assign out_row_weighted_sum = out_row_sum_r;
  assign out_col_sum          = out_col_sum_r;
  assign out_first_line       = out_first_line_r;
  assign out_last_line        = out_last_line_r;
  assign out_min_col          = out_min_col_r;
  assign out_max_col          = out_max_col_r;
  assign out_frame_last       = out_frame_last_r;

  `RPPF_ASSERT_NXT(a_frame_end_gives_result, pop && rec_frame_end, out_valid_r && out_frame_last_r)
  `RPPF_ASSERT_IMP(a_post_lines_ordered, in_post_r, post_first_line_r <= post_last_line_r)
  `RPPF_ASSERT_IMP(a_post_cols_ordered, in_post_r, post_min_col_r <= post_max_col_r)

endmodule

// ===== tb/tb_row_projection_post_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row projection post finder testbench
// Streams label frames of many geometries, masks and thresholds through the
// post finder, mostly under random source and sink gaps. Each accepted pixel
// transaction is run through a line-merge predictor, and every result
// transaction is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_row_projection_post_finder;
  import rppf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic                 post_valid;
    logic [AREA_W-1:0]    area;
    logic [SUM_OUT_W-1:0] row_weighted_sum;
    logic [SUM_OUT_W-1:0] col_sum;
    logic [POS_OUT_W-1:0] first_line;
    logic [POS_OUT_W-1:0] last_line;
    logic [POS_OUT_W-1:0] min_col;
    logic [POS_OUT_W-1:0] max_col;
    logic                 frame_last;
  } post_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_post_valid;
  logic [AREA_W-1:0]     out_area;
  logic [SUM_OUT_W-1:0]  out_row_weighted_sum;
  logic [SUM_OUT_W-1:0]  out_col_sum;
  logic [POS_OUT_W-1:0]  out_first_line;
  logic [POS_OUT_W-1:0]  out_last_line;
  logic [POS_OUT_W-1:0]  out_min_col;
  logic [POS_OUT_W-1:0]  out_max_col;
  logic                  out_frame_last;

  bit [7:0]  pixel_q[$];
  post_rec_t post_expect_q[$];
  int        idle_pct;
  int        mismatch_cnt;
  int        cycle_cnt;
  int        random_items;
  bit        in_took;

  bit [7:0]  cur_mask;
  bit [8:0]  cur_thresh;
  bit [8:0]  cur_lines;
  bit [8:0]  cur_len;

  bit [7:0]  scan_line;
  bit [7:0]  scan_col;
  bit [8:0]  run_count;
  bit [7:0]  run_min;
  bit [7:0]  run_max;
  bit [14:0] run_colsum;
  bit        post_open;
  bit [16:0] acc_area;
  bit [22:0] acc_rowsum;
  bit [22:0] acc_colsum;
  bit [7:0]  acc_first;
  bit [7:0]  acc_last;
  bit [7:0]  acc_min;
  bit [7:0]  acc_max;

  row_projection_post_finder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_pixel             (in_pixel),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_post_valid       (out_post_valid),
    .out_area             (out_area),
    .out_row_weighted_sum (out_row_weighted_sum),
    .out_col_sum          (out_col_sum),
    .out_first_line       (out_first_line),
    .out_last_line        (out_last_line),
    .out_min_col          (out_min_col),
    .out_max_col          (out_max_col),
    .out_frame_last       (out_frame_last)
  );

  always #2 clk = ~clk;

  function automatic bit [8:0] eff_dim(input bit [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

  function automatic post_rec_t make_post(input bit valid, input bit last);
    post_rec_t r;
    r = '0;
    if (valid) begin
      r.post_valid       = 1'b1;
      r.area             = acc_area;
      r.row_weighted_sum = acc_rowsum;
      r.col_sum          = acc_colsum;
      r.first_line       = acc_first;
      r.last_line        = acc_last;
      r.min_col          = acc_min;
      r.max_col          = acc_max;
    end
    r.frame_last = last;
    return r;
  endfunction

  function automatic string post_str(input post_rec_t r);
    return $sformatf("pv=%0d area=%0d rws=%0d cs=%0d lines=%0d..%0d cols=%0d..%0d fl=%0d",
                     r.post_valid, r.area, r.row_weighted_sum, r.col_sum, r.first_line,
                     r.last_line, r.min_col, r.max_col, r.frame_last);
  endfunction

  task automatic project_pixel(input bit [7:0] px);
    bit [8:0] len;
    bit [8:0] lines;
    bit       closed;
    len    = eff_dim(cur_len);
    lines  = eff_dim(cur_lines);
    closed = 1'b0;
    if ((px & cur_mask) != 8'h00) begin
      run_count = run_count + 9'd1;
      if (scan_col < run_min) run_min = scan_col;
      if (scan_col > run_max) run_max = scan_col;
      run_colsum = run_colsum + 15'(scan_col);
    end
    if ({1'b0, scan_col} + 9'd1 < len) begin
      scan_col = scan_col + 8'd1;
      return;
    end
    if (run_count > cur_thresh) begin
      if (!post_open) begin
        acc_area   = 17'(run_count);
        acc_rowsum = 23'(run_count) * 23'(scan_line);
        acc_colsum = 23'(run_colsum);
        acc_first  = scan_line;
        acc_last   = scan_line;
        acc_min    = run_min;
        acc_max    = run_max;
        post_open  = 1'b1;
      end else begin
        acc_area   = acc_area + 17'(run_count);
        acc_rowsum = acc_rowsum + 23'(run_count) * 23'(scan_line);
        acc_colsum = acc_colsum + 23'(run_colsum);
        acc_last   = scan_line;
        if (run_min < acc_min) acc_min = run_min;
        if (run_max > acc_max) acc_max = run_max;
      end
    end else if (post_open) begin
      closed    = 1'b1;
      post_open = 1'b0;
    end
    scan_col   = 8'd0;
    run_count  = 9'd0;
    run_min    = 8'(len - 9'd1);
    run_max    = 8'd0;
    run_colsum = 15'd0;
    if ({1'b0, scan_line} + 9'd1 < lines) begin
      scan_line = scan_line + 8'd1;
      if (closed) post_expect_q.insert(post_expect_q.size(), make_post(1'b1, 1'b0));
      return;
    end
    scan_line = 8'd0;
    if (closed || post_open) begin
      post_open = 1'b0;
      post_expect_q.insert(post_expect_q.size(), make_post(1'b1, 1'b1));
    end else begin
      post_expect_q.insert(post_expect_q.size(), make_post(1'b0, 1'b1));
    end
  endtask

  function automatic bit [7:0] gen_pixel(input bit want_set);
    bit [7:0] v;
    int       b;
    v = 8'($urandom_range(255));
    if (cur_mask == 8'h00 || $urandom_range(99) < 8) return v;
    if (want_set) begin
      do b = $urandom_range(7); while (!cur_mask[b]);
      v[b] = 1'b1;
    end else begin
      v = v & ~cur_mask;
    end
    return v;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input bit [8:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PIXEL_MASK:     cur_mask   = val[7:0];
      CFG_POST_THRESHOLD: cur_thresh = val;
      CFG_LINE_COUNT:     cur_lines  = val;
      CFG_LINE_LENGTH:    cur_len    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input bit [7:0] mask, input bit [8:0] thr,
                          input bit [8:0] lines, input bit [8:0] len);
    write_reg(CFG_PIXEL_MASK, {1'($urandom_range(1)), mask});
    write_reg(CFG_POST_THRESHOLD, thr);
    write_reg(CFG_LINE_COUNT, lines);
    write_reg(CFG_LINE_LENGTH, len);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || post_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_frames(input int nframes, input bit partial);
    int  len;
    int  total;
    int  cut;
    int  mode;
    bit  want;
    len   = int'(eff_dim(cur_len));
    total = nframes * len * int'(eff_dim(cur_lines));
    cut   = (partial && total > 1) ? $urandom_range(1, total - 1) : total;
    mode  = $urandom_range(3);
    for (int i = 0; i < cut; i++) begin
      if (i % len == 0 && $urandom_range(99) < 40) mode = $urandom_range(3);
      case (mode)
        0:       want = 1'b0;
        1:       want = ($urandom_range(99) < 15);
        2:       want = ($urandom_range(99) < 85);
        default: want = 1'b1;
      endcase
      pixel_q.insert(pixel_q.size(), gen_pixel(want));
    end
    random_items += cut;
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Pixel transactions are predicted at the edge that accepts them.
  always @(posedge clk) begin
    post_rec_t got;
    post_rec_t want;
    in_took = in_valid && in_ready;
    if (rst_n && in_took) project_pixel(in_pixel);
    if (rst_n && out_valid && out_ready) begin
      got = '{out_post_valid, out_area, out_row_weighted_sum, out_col_sum, out_first_line,
              out_last_line, out_min_col, out_max_col, out_frame_last};
      if (post_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result at cycle %0d: %s", cycle_cnt, post_str(got));
      end else begin
        want = post_expect_q.pop_front();
        if (got.post_valid !== want.post_valid || got.area !== want.area ||
            got.row_weighted_sum !== want.row_weighted_sum || got.col_sum !== want.col_sum ||
            got.first_line !== want.first_line || got.last_line !== want.last_line ||
            got.min_col !== want.min_col || got.max_col !== want.max_col ||
            got.frame_last !== want.frame_last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
                     cycle_cnt, post_str(want), post_str(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_row_projection_post_finder: errors");
      $finish;
    end
  end

  initial begin
    int  phase;
    int  len_v;
    int  lines_v;
    int  thr_v;
    int  mask_v;
    int  nframes;
    bit  big;
    bit  calm;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PIXEL_MASK;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_pixel  = 8'h00;
    out_ready = 1'b0;
    idle_pct  = 31;
    cur_mask   = PIXEL_MASK_RST;
    cur_thresh = POST_THRESHOLD_RST;
    cur_lines  = LINE_COUNT_RST;
    cur_len    = LINE_LENGTH_RST;
    scan_line  = 8'd0;
    scan_col   = 8'd0;
    run_count  = 9'd0;
    run_min    = 8'(eff_dim(cur_len) - 9'd1);
    run_max    = 8'd0;
    run_colsum = 15'd0;
    post_open  = 1'b0;
    acc_area   = '0;
    acc_rowsum = '0;
    acc_colsum = '0;
    acc_first  = '0;
    acc_last   = '0;
    acc_min    = '0;
    acc_max    = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    set_regs(8'h80, 9'd1, 9'd3, 9'd4);
    pixel_q = {8'h80, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h80, 8'h00,
               8'h7F, 8'h00, 8'h3C, 8'h00};
    wait_quiet();
    set_regs(8'hFF, 9'd256, 9'd0, 9'd0);
    pixel_q = {8'hFF};
    wait_quiet();
    write_reg(CFG_POST_THRESHOLD, 9'd0);
    pixel_q = {8'h01};
    wait_quiet();
    write_reg(CFG_PIXEL_MASK, 9'd0);
    pixel_q = {8'hFF};
    wait_quiet();
    set_regs(8'h01, 9'd0, 9'd4, 9'd4);
    pixel_q = {8'h01, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01};
    wait_quiet();
    write_reg(CFG_LINE_LENGTH, 9'd2);
    pixel_q = {8'h00, 8'h00, 8'hFE};
    wait_quiet();
    write_reg(CFG_LINE_COUNT, 9'd2);
    pixel_q = {8'h01, 8'h03};
    wait_quiet();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      big  = (phase == 3 || phase == 7);
      calm = (phase % 6 == 5) || phase == 3;
      if (phase == 3) begin
        mask_v  = $urandom_range(255);
        thr_v   = $urandom_range(0, 200);
        lines_v = 1;
        len_v   = 511;
      end else if (phase == 7) begin
        mask_v  = $urandom_range(1, 255);
        thr_v   = 0;
        lines_v = 300;
        len_v   = 1;
      end else begin
        len_v   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        lines_v = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        case ($urandom_range(9))
          0, 1:    mask_v = 8'hFF;
          2:       mask_v = 8'h00;
          default: mask_v = $urandom_range(255);
        endcase
        thr_v = ($urandom_range(9) == 0) ? $urandom_range(256, 511)
                                         : $urandom_range(0, eff_dim(9'(len_v)));
      end
      idle_pct = calm ? 0 : 31;
      set_regs(8'(mask_v), 9'(thr_v), 9'(lines_v), 9'(len_v));
      nframes = big ? 1 : $urandom_range(1, 4);
      load_frames(nframes, !big && $urandom_range(4) == 0);
      wait_quiet();
      phase++;
    end

    idle_pct = 31;
    wait_quiet();
    if (mismatch_cnt == 0 && post_expect_q.size() == 0)
      $display("tb_row_projection_post_finder: clean");
    else
      $display("tb_row_projection_post_finder: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rppf_pkg.sv
rtl/rppf_front.sv
rtl/rppf_queue.sv
rtl/rppf_back.sv
rtl/row_projection_post_finder.sv
tb/tb_row_projection_post_finder.sv
